### src/kvrt_pkg.sv
// Shared types, constants and operation codes for the known-value register tracker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package kvrt_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_AW    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int DATA_W    = 64;
  localparam int IDX_W     = 5;
  localparam int IMM_W     = 20;
  localparam int OP_W      = 4;
  localparam int CNT_W     = $clog2(DATA_W);
  localparam int LUI_SHIFT = 12;

  localparam logic [IDX_W-1:0] A0_INDEX = 5'd10;

  // instruction operation codes
  localparam logic [OP_W-1:0] OP_ADDI  = 4'd0;
  localparam logic [OP_W-1:0] OP_LUI   = 4'd1;
  localparam logic [OP_W-1:0] OP_LD    = 4'd2;
  localparam logic [OP_W-1:0] OP_SD    = 4'd3;
  localparam logic [OP_W-1:0] OP_BEQ   = 4'd4;
  localparam logic [OP_W-1:0] OP_JAL   = 4'd5;
  localparam logic [OP_W-1:0] OP_JALR  = 4'd6;
  localparam logic [OP_W-1:0] OP_ECALL = 4'd7;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd8;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd9;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd10;
  localparam logic [OP_W-1:0] OP_DIVU  = 4'd11;
  localparam logic [OP_W-1:0] OP_REMU  = 4'd12;
  localparam logic [OP_W-1:0] OP_SLTU  = 4'd13;

  // shared unit operation codes
  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SUB  = 3'd1;
  localparam logic [2:0] ALU_SLTU = 3'd2;
  localparam logic [2:0] ALU_MUL  = 3'd3;
  localparam logic [2:0] ALU_DIVU = 3'd4;
  localparam logic [2:0] ALU_REMU = 3'd5;

  typedef struct packed {
    logic              start;
    logic [2:0]        op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } kvrt_alu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] result;
  } kvrt_alu_rsp_t;

  typedef struct packed {
    logic              en;
    logic              known;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } kvrt_wr_t;

  // register zero and numbers past the file read as a known zero
  function automatic logic idx_is_zero(input logic [IDX_W-1:0] idx);
    return (idx == '0) || (int'(idx) >= REG_COUNT);
  endfunction

endpackage

`default_nettype wire

### src/kvrt_if.sv
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on kvrt_pkg for field widths.
`default_nettype none

interface kvrt_in_if import kvrt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [IDX_W-1:0]        dest_index;
  logic [IDX_W-1:0]        src1_index;
  logic [IDX_W-1:0]        src2_index;
  logic signed [IMM_W-1:0] immediate;

  modport source (output valid, operation, dest_index, src1_index, src2_index, immediate,
                  input ready);
  modport sink   (input valid, operation, dest_index, src1_index, src2_index, immediate,
                  output ready);
endinterface

interface kvrt_out_if import kvrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              tracked;
  logic              reg_written;
  logic [IDX_W-1:0]  written_index;
  logic              written_known;
  logic [DATA_W-1:0] written_value;

  modport source (output valid, tracked, reg_written, written_index, written_known,
                  written_value, input ready);
  modport sink   (input valid, tracked, reg_written, written_index, written_known,
                  written_value, output ready);
endinterface

`default_nettype wire

### src/kvrt_regfile.sv
// Tracked register file: value memory with one registered read port, known flags in flops.
// Depends on kvrt_pkg.
`default_nettype none

module kvrt_regfile import kvrt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [IDX_W-1:0]     rd_addr,
  output logic      [DATA_W-1:0]    rd_data,
  input  wire kvrt_wr_t             wr,
  output logic      [REG_COUNT-1:0] known_vec
);

  logic [DATA_W-1:0]    mem_r [REG_COUNT];
  logic [DATA_W-1:0]    rd_data_r;
  logic [REG_COUNT-1:0] known_r;

  // values only matter while known, so the memory needs no clearing
  always_ff @(posedge clk) begin
    if (wr.en && wr.known) begin
      mem_r[REG_AW'(wr.idx)] <= wr.value;
    end
    rd_data_r <= mem_r[REG_AW'(rd_addr)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= REG_COUNT'(1);
    end else if (wr.en) begin
      known_r[REG_AW'(wr.idx)] <= wr.known;
    end
  end

  assign rd_data   = rd_data_r;
  assign known_vec = known_r;

endmodule

`default_nettype wire

### src/kvrt_alu.sv
// Shared 64-bit unit: one adder serves add/sub/sltu in one step, shift-add multiply
// and restoring divide over 64 steps. Depends on kvrt_pkg.
`default_nettype none

module kvrt_alu import kvrt_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire kvrt_alu_req_t req,
  output kvrt_alu_rsp_t      rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] aux_r, aux_nxt;
  logic [DATA_W-1:0] opnd_r, opnd_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [DATA_W:0]   add_x, add_y;
  logic              add_sub;
  logic [DATA_W+1:0] add_sum;
  logic              carry;

  assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                 + (DATA_W+2)'(add_sub);
  assign carry   = add_sum[DATA_W+1];

  // operand selection for the single adder
  always_comb begin
    add_x   = {1'b0, req.a};
    add_y   = {1'b0, req.b};
    add_sub = (req.op != ALU_ADD);
    if (busy_r) begin
      if (op_r == ALU_MUL) begin
        add_x   = {1'b0, acc_r};
        add_y   = aux_r[0] ? {1'b0, opnd_r} : '0;
        add_sub = 1'b0;
      end else begin
        // partial remainder with next dividend bit shifted in
        add_x   = {acc_r, aux_r[DATA_W-1]};
        add_y   = {1'b0, opnd_r};
        add_sub = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    aux_nxt  = aux_r;
    opnd_nxt = opnd_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    if (busy_r) begin
      if (op_r == ALU_MUL) begin
        acc_nxt  = add_sum[DATA_W-1:0];
        aux_nxt  = aux_r >> 1;
        opnd_nxt = opnd_r << 1;
      end else begin
        acc_nxt = carry ? add_sum[DATA_W-1:0] : add_x[DATA_W-1:0];
        aux_nxt = {aux_r[DATA_W-2:0], carry};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = (op_r == ALU_DIVU) ? aux_nxt : acc_nxt;
      end
    end else if (req.start) begin
      op_nxt = req.op;
      case (req.op)
        ALU_ADD, ALU_SUB: begin
          res_nxt  = add_sum[DATA_W-1:0];
          done_nxt = 1'b1;
        end
        ALU_SLTU: begin
          res_nxt  = DATA_W'(!carry);
          done_nxt = 1'b1;
        end
        ALU_MUL: begin
          acc_nxt  = '0;
          aux_nxt  = req.b;
          opnd_nxt = req.a;
          cnt_nxt  = CNT_W'(DATA_W-1);
          busy_nxt = 1'b1;
        end
        ALU_DIVU, ALU_REMU: begin
          acc_nxt  = '0;
          aux_nxt  = req.a;
          opnd_nxt = req.b;
          cnt_nxt  = CNT_W'(DATA_W-1);
          busy_nxt = 1'b1;
        end
        default: begin
          res_nxt  = '0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ALU_ADD;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    aux_r  <= aux_nxt;
    opnd_r <= opnd_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

`default_nettype wire

### src/known_value_register_tracker_top.sv
// Known-value register tracker: sequencer over the register file and the shared unit.
// Depends on kvrt_pkg, kvrt_if, kvrt_regfile and kvrt_alu.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    operation, dest_index, src1_index, src2_index, immediate
//   out_chan  out  valid/ready    tracked, reg_written, written_index, written_known,
//                                 written_value
//
// One instruction beat at a time: accept, read rs1 then rs2 through the single memory
// read port (captured in S_RD1, S_RD2), decode (S_EXEC), then the shared unit if needed.
// add/sub/sltu/addi are done by the shared adder when started; mul/divu/remu wait in
// S_ALU while its one-bit-per-step loop runs.
// The result sits in an output register; the next beat is taken while it waits, but its
// own result holds back until that register is free.
// Reset: only register zero known; no clearing pass.
`default_nettype none

module known_value_register_tracker_top import kvrt_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  kvrt_in_if.sink    in_chan,
  kvrt_out_if.source out_chan
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_ALU  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [OP_W-1:0]         op_r, op_nxt;
  logic [IDX_W-1:0]        rd_r, rd_nxt;
  logic [IDX_W-1:0]        rs1_r, rs1_nxt;
  logic [IDX_W-1:0]        rs2_r, rs2_nxt;
  logic signed [IMM_W-1:0] imm_r, imm_nxt;
  logic [DATA_W-1:0]       a_r, a_nxt;
  logic [DATA_W-1:0]       b_r, b_nxt;
  logic                    a_known_r, a_known_nxt;
  logic                    b_known_r, b_known_nxt;
  logic                    tracked_r, tracked_nxt;
  kvrt_wr_t                wr_r, wr_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_tracked_r, out_tracked_nxt;
  kvrt_wr_t                out_wr_r, out_wr_nxt;

  logic [IDX_W-1:0]        rf_addr;
  logic [DATA_W-1:0]       rf_data;
  logic [REG_COUNT-1:0]    known_vec;
  kvrt_wr_t                rf_wr;
  kvrt_alu_req_t           alu_req;
  kvrt_alu_rsp_t           alu_rsp;

  logic                    in_beat;
  logic                    slot_free;
  logic                    commit;
  logic [DATA_W-1:0]       imm64;
  logic                    cur_zero;
  logic                    cur_known;

  assign in_beat   = in_chan.valid && in_chan.ready;
  assign slot_free = !out_valid_r || out_chan.ready;
  assign commit    = (state_r == S_DONE) && slot_free;
  assign imm64     = {{(DATA_W-IMM_W){imm_r[IMM_W-1]}}, imm_r};

  // rs1 is read on the accept cycle, rs2 in the cycle after (S_RD1)
  assign rf_addr   = (state_r == S_IDLE) ? in_chan.src1_index : rs2_r;

  // index of the register whose read data arrives this cycle
  always_comb begin
    cur_zero  = idx_is_zero((state_r == S_RD1) ? rs1_r : rs2_r);
    cur_known = cur_zero ||
                known_vec[REG_AW'((state_r == S_RD1) ? rs1_r : rs2_r)];
  end

  function automatic kvrt_wr_t wr_unknown(input logic [IDX_W-1:0] idx);
    kvrt_wr_t w;
    w       = '0;
    w.en    = !idx_is_zero(idx);
    w.idx   = w.en ? idx : '0;
    return w;
  endfunction

  function automatic kvrt_wr_t wr_value(input logic [IDX_W-1:0] idx,
                                        input logic [DATA_W-1:0] v);
    kvrt_wr_t w;
    w       = '0;
    w.en    = !idx_is_zero(idx);
    w.known = w.en;
    w.idx   = w.en ? idx : '0;
    w.value = w.en ? v : '0;
    return w;
  endfunction

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    rd_nxt      = rd_r;
    rs1_nxt     = rs1_r;
    rs2_nxt     = rs2_r;
    imm_nxt     = imm_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    a_known_nxt = a_known_r;
    b_known_nxt = b_known_r;
    tracked_nxt = tracked_r;
    wr_nxt      = wr_r;
    alu_req     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          op_nxt    = in_chan.operation;
          rd_nxt    = in_chan.dest_index;
          rs1_nxt   = in_chan.src1_index;
          rs2_nxt   = in_chan.src2_index;
          imm_nxt   = in_chan.immediate;
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        a_nxt       = cur_zero ? '0 : rf_data;
        a_known_nxt = cur_known;
        state_nxt   = S_RD2;
      end
      S_RD2: begin
        b_nxt       = cur_zero ? '0 : rf_data;
        b_known_nxt = cur_known;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        tracked_nxt = 1'b0;
        wr_nxt      = '0;
        state_nxt   = S_DONE;
        case (op_r)
          OP_ADDI: begin
            if (a_known_r) begin
              tracked_nxt   = 1'b1;
              alu_req.start = 1'b1;
              alu_req.op    = ALU_ADD;
              alu_req.a     = a_r;
              alu_req.b     = imm64;
              state_nxt     = S_ALU;
            end else begin
              wr_nxt = wr_unknown(rd_r);
            end
          end
          OP_LUI: begin
            tracked_nxt = 1'b1;
            wr_nxt      = wr_value(rd_r, imm64 << LUI_SHIFT);
          end
          OP_LD, OP_JAL, OP_JALR: begin
            wr_nxt = wr_unknown(rd_r);
          end
          OP_ECALL: begin
            wr_nxt = wr_unknown(A0_INDEX);
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIVU, OP_REMU, OP_SLTU: begin
            if (!a_known_r || !b_known_r) begin
              wr_nxt = wr_unknown(rd_r);
            end else begin
              tracked_nxt = 1'b1;
              // zero divisor leaves rd as it was
              if (!((op_r == OP_DIVU || op_r == OP_REMU) && b_r == '0)) begin
                alu_req.start = 1'b1;
                alu_req.a     = a_r;
                alu_req.b     = b_r;
                state_nxt     = S_ALU;
                case (op_r)
                  OP_SUB:  alu_req.op = ALU_SUB;
                  OP_MUL:  alu_req.op = ALU_MUL;
                  OP_DIVU: alu_req.op = ALU_DIVU;
                  OP_REMU: alu_req.op = ALU_REMU;
                  OP_SLTU: alu_req.op = ALU_SLTU;
                  default: alu_req.op = ALU_ADD;
                endcase
              end
            end
          end
          default: begin
            wr_nxt = '0;
          end
        endcase
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          wr_nxt    = wr_value(rd_r, alu_rsp.result);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // write-back and result load happen together once the output register is free
  always_comb begin
    rf_wr           = wr_r;
    rf_wr.en        = wr_r.en && commit;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_tracked_nxt = out_tracked_r;
    out_wr_nxt      = out_wr_r;
    if (commit) begin
      out_valid_nxt   = 1'b1;
      out_tracked_nxt = tracked_r;
      out_wr_nxt      = wr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    rd_r          <= rd_nxt;
    rs1_r         <= rs1_nxt;
    rs2_r         <= rs2_nxt;
    imm_r         <= imm_nxt;
    a_r           <= a_nxt;
    b_r           <= b_nxt;
    a_known_r     <= a_known_nxt;
    b_known_r     <= b_known_nxt;
    tracked_r     <= tracked_nxt;
    wr_r          <= wr_nxt;
    out_tracked_r <= out_tracked_nxt;
    out_wr_r      <= out_wr_nxt;
  end

  kvrt_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rf_addr),
    .rd_data   (rf_data),
    .wr        (rf_wr),
    .known_vec (known_vec)
  );

  kvrt_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.tracked       = out_tracked_r;
  assign out_chan.reg_written   = out_wr_r.en;
  assign out_chan.written_index = out_wr_r.idx;
  assign out_chan.written_known = out_wr_r.known;
  assign out_chan.written_value = out_wr_r.value;

  a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !alu_rsp.busy)
    else $error("beat accepted while shared unit busy");

  a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_wr.en |-> (rf_wr.idx != '0))
    else $error("write to register zero");

  a_done_in_alu: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> (state_r == S_ALU))
    else $error("unit result outside wait state");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed result not presented");

endmodule

`default_nettype wire

### sim/known_value_register_tracker_checker.sv
// Scoreboard for the known-value register tracker: watches both channels, keeps a shadow
// register file and compares every result beat with the predicted one.
// Depends on kvrt_pkg and the channel interfaces in kvrt_if.
module known_value_register_tracker_checker import kvrt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  kvrt_in_if   in_mon,
  kvrt_out_if  out_mon,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              tracked;
    logic              reg_written;
    logic [IDX_W-1:0]  written_index;
    logic              written_known;
    logic [DATA_W-1:0] written_value;
  } tracker_result_t;

  logic [DATA_W-1:0] shadow_value [REG_COUNT];
  logic              shadow_known [REG_COUNT];
  tracker_result_t   pending_results [$];

  // register zero and anything past the file read as a known zero
  function automatic logic operand_known(input logic [IDX_W-1:0] r);
    if (r == '0 || int'(r) >= REG_COUNT) return 1'b1;
    return shadow_known[r];
  endfunction

  function automatic logic [DATA_W-1:0] operand_value(input logic [IDX_W-1:0] r);
    if (r == '0 || int'(r) >= REG_COUNT) return '0;
    return shadow_value[r];
  endfunction

  // applies one instruction to the shadow file and returns the result beat it should give
  function automatic tracker_result_t track_instruction(
    input logic [OP_W-1:0]  op,
    input logic [IDX_W-1:0] rd,
    input logic [IDX_W-1:0] rs1,
    input logic [IDX_W-1:0] rs2,
    input logic [IMM_W-1:0] imm
  );
    tracker_result_t   res;
    logic [DATA_W-1:0] imm_ext;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] new_value;
    logic [IDX_W-1:0]  dst;
    logic              make_known;
    logic              make_unknown;
    res          = '0;
    imm_ext      = {{(DATA_W-IMM_W){imm[IMM_W-1]}}, imm};
    a            = operand_value(rs1);
    b            = operand_value(rs2);
    new_value    = '0;
    dst          = rd;
    make_known   = 1'b0;
    make_unknown = 1'b0;
    case (op)
      OP_ADDI: begin
        if (operand_known(rs1)) begin
          res.tracked = 1'b1;
          make_known  = 1'b1;
          new_value   = a + imm_ext;
        end else begin
          make_unknown = 1'b1;
        end
      end
      OP_LUI: begin
        res.tracked = 1'b1;
        make_known  = 1'b1;
        new_value   = imm_ext << LUI_SHIFT;
      end
      OP_LD, OP_JAL, OP_JALR: begin
        make_unknown = 1'b1;
      end
      OP_ECALL: begin
        dst          = A0_INDEX;
        make_unknown = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIVU, OP_REMU, OP_SLTU: begin
        if (!operand_known(rs1) || !operand_known(rs2)) begin
          make_unknown = 1'b1;
        end else begin
          res.tracked = 1'b1;
          make_known  = 1'b1;
          case (op)
            OP_ADD:  new_value = a + b;
            OP_SUB:  new_value = a - b;
            OP_MUL:  new_value = a * b;
            // zero divisor leaves rd alone
            OP_DIVU: begin
              if (b == '0) make_known = 1'b0;
              else new_value = a / b;
            end
            OP_REMU: begin
              if (b == '0) make_known = 1'b0;
              else new_value = a % b;
            end
            default: new_value = (a < b) ? DATA_W'(1) : '0;
          endcase
        end
      end
      default: ;
    endcase
    if ((make_known || make_unknown) && dst != '0 && int'(dst) < REG_COUNT) begin
      // an unknown entry keeps its stale value; it is never used while unknown
      shadow_known[dst] = make_known;
      if (make_known) shadow_value[dst] = new_value;
      res.reg_written   = 1'b1;
      res.written_index = dst;
      res.written_known = make_known;
      res.written_value = make_known ? new_value : '0;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    tracker_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        shadow_value[i] = '0;
        shadow_known[i] = (i == 0);
      end
      pending_results.delete();
      fail_count  = 0;
      outstanding = 0;
    end else begin
      // result side first: a beat cannot belong to an instruction taken on the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no instruction outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("tracked", want.tracked, out_mon.tracked);
          check_field("reg_written", want.reg_written, out_mon.reg_written);
          check_field("written_index", want.written_index, out_mon.written_index);
          check_field("written_known", want.written_known, out_mon.written_known);
          check_field("written_value", want.written_value, out_mon.written_value);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(track_instruction(in_mon.operation, in_mon.dest_index,
                                                    in_mon.src1_index, in_mon.src2_index,
                                                    in_mon.immediate));
      end
      outstanding = pending_results.size();
    end
  end

endmodule

### sim/known_value_register_tracker_top_tb.sv
// Testbench top for known_value_register_tracker_top: clock, reset, instruction stimulus,
// result-side back-pressure and the verdict.
// Depends on kvrt_pkg, kvrt_if, the RTL and known_value_register_tracker_checker.
module known_value_register_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kvrt_pkg::*;

  localparam int LONG_STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES      = 100;
  localparam int PHASE_BEATS       = 275;
  localparam int PHASE_COUNT       = 4;

  localparam logic [OP_W-1:0]  OP_RSVD_14 = 4'd14;
  localparam logic [OP_W-1:0]  OP_RSVD_15 = 4'd15;
  localparam logic [IMM_W-1:0] IMM_MAX    = 20'h7FFFF;
  localparam logic [IMM_W-1:0] IMM_MIN    = 20'h80000;
  localparam logic [IMM_W-1:0] IMM_NEG1   = 20'hFFFFF;

  localparam logic [OP_W-1:0] TWO_SRC_OPS [6] = '{OP_ADD, OP_SUB, OP_MUL,
                                                  OP_DIVU, OP_REMU, OP_SLTU};
  localparam int SEND_IDLE_PCT  [PHASE_COUNT] = '{0, 45, 0, 24};
  localparam int RECV_STALL_PCT [PHASE_COUNT] = '{0, 0, 45, 24};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  bit   long_stall_req = 1'b0;
  int   fail_count;
  int   outstanding;

  kvrt_in_if  in_bus ();
  kvrt_out_if out_bus ();

  known_value_register_tracker_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  known_value_register_tracker_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  initial begin
    #6ms;
    $display("known_value_register_tracker_top regression: fail");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] rd,
                           input logic [IDX_W-1:0] rs1, input logic [IDX_W-1:0] rs2,
                           input logic [IMM_W-1:0] imm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= op;
    in_bus.dest_index <= rd;
    in_bus.src1_index <= rs1;
    in_bus.src2_index <= rs2;
    in_bus.immediate  <= imm;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  // mostly a small pool, so values written are read back soon after
  function automatic logic [IDX_W-1:0] pick_reg();
    if ($urandom_range(3) != 0) return IDX_W'($urandom_range(7));
    return IDX_W'($urandom());
  endfunction

  task automatic send_random_instr();
    int               pick;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] rs1;
    logic [IMM_W-1:0] imm;
    pick = $urandom_range(99);
    rs1  = pick_reg();
    imm  = IMM_W'($urandom());
    case ($urandom_range(7))
      0, 1: imm = IMM_W'(int'($urandom_range(16)) - 8);
      2:    imm = $urandom_range(1) ? IMM_MAX : IMM_MIN;
      default: ;
    endcase
    if (pick < 15) begin
      op = OP_LUI;
    end else if (pick < 35) begin
      op = OP_ADDI;
      if ($urandom_range(1)) rs1 = '0;
    end else if (pick < 82) begin
      op = TWO_SRC_OPS[$urandom_range(5)];
    end else begin
      op = OP_W'($urandom_range(15));
    end
    send_beat(op, pick_reg(), rs1, pick_reg(), imm);
  endtask

  initial begin
    in_bus.valid      <= 1'b0;
    in_bus.operation  <= OP_ADDI;
    in_bus.dest_index <= '0;
    in_bus.src1_index <= '0;
    in_bus.src2_index <= '0;
    in_bus.immediate  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every operation, the corner cases
    send_beat(OP_LUI,   5'd1,  5'd0,  5'd0,  IMM_MAX);
    send_beat(OP_LUI,   5'd2,  5'd0,  5'd0,  IMM_MIN);
    send_beat(OP_ADDI,  5'd3,  5'd0,  5'd0,  IMM_NEG1);
    send_beat(OP_ADDI,  5'd4,  5'd0,  5'd0,  IMM_MAX);
    send_beat(OP_ADDI,  5'd5,  5'd1,  5'd0,  IMM_MIN);
    send_beat(OP_ADD,   5'd6,  5'd3,  5'd3,  '0);
    send_beat(OP_SUB,   5'd7,  5'd0,  5'd4,  '0);
    send_beat(OP_MUL,   5'd8,  5'd2,  5'd2,  '0);
    send_beat(OP_DIVU,  5'd9,  5'd3,  5'd4,  '0);
    send_beat(OP_REMU,  5'd10, 5'd3,  5'd4,  '0);
    send_beat(OP_DIVU,  5'd11, 5'd3,  5'd0,  '0);
    send_beat(OP_REMU,  5'd11, 5'd3,  5'd0,  '0);
    send_beat(OP_SLTU,  5'd12, 5'd4,  5'd3,  '0);
    send_beat(OP_SLTU,  5'd12, 5'd3,  5'd4,  '0);
    send_beat(OP_ADDI,  5'd0,  5'd1,  5'd0,  IMM_MAX);
    send_beat(OP_LD,    5'd13, 5'd1,  5'd0,  '0);
    send_beat(OP_LD,    5'd13, 5'd1,  5'd0,  '0);
    send_beat(OP_ADD,   5'd14, 5'd13, 5'd1,  '0);
    send_beat(OP_ADDI,  5'd15, 5'd13, 5'd0,  IMM_NEG1);
    send_beat(OP_SD,    5'd1,  5'd2,  5'd3,  IMM_MAX);
    send_beat(OP_BEQ,   5'd1,  5'd1,  5'd1,  IMM_MIN);
    send_beat(OP_JAL,   5'd16, 5'd0,  5'd0,  IMM_MAX);
    send_beat(OP_JALR,  5'd17, 5'd1,  5'd0,  IMM_MIN);
    send_beat(OP_ECALL, 5'd31, 5'd31, 5'd31, IMM_NEG1);
    send_beat(OP_MUL,   5'd18, A0_INDEX, 5'd1, '0);
    send_beat(OP_RSVD_14, 5'd1, 5'd2, 5'd3,  IMM_NEG1);
    send_beat(OP_RSVD_15, 5'd31, 5'd31, 5'd31, IMM_MAX);
    send_beat(OP_ADDI,  5'd31, 5'd31, 5'd0,  IMM_NEG1);
    send_beat(OP_LUI,   5'd31, 5'd31, 5'd31, IMM_NEG1);
    drain_results();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      send_idle_pct  = SEND_IDLE_PCT[phase];
      recv_stall_pct = RECV_STALL_PCT[phase];
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // long hold-off on the result side while beats keep coming
        if (phase == 0 && n == PHASE_BEATS / 2) long_stall_req = 1'b1;
        send_random_instr();
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("known_value_register_tracker_top regression: pass");
    end else begin
      $display("known_value_register_tracker_top regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
src/kvrt_pkg.sv
src/kvrt_if.sv
src/kvrt_regfile.sv
src/kvrt_alu.sv
src/known_value_register_tracker_top.sv
sim/known_value_register_tracker_checker.sv
sim/known_value_register_tracker_top_tb.sv
